// ===== hdl/dts_pkg.sv =====
// dts_pkg: shared types, constants and helpers of the DFA token scanner.
// Used by dts_front, dts_engine and dfa_token_scanner; depends on nothing.

package dts_pkg;

  // Default sizing
  localparam int NUM_STATES_DEF = 256;
  localparam int NUM_KINDS_DEF  = 64;

  // Queue depths between the parts
  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  // Character constants
  localparam logic [7:0] CHAR_NL = 8'd10;

  // Item opcodes as they arrive on the input channel
  localparam logic [2:0] OPC_TRANS  = 3'd0;
  localparam logic [2:0] OPC_INFO   = 3'd1;
  localparam logic [2:0] OPC_IGNORE = 3'd2;
  localparam logic [2:0] OPC_CHAR   = 3'd3;
  localparam logic [2:0] OPC_EOF    = 3'd4;

  // Classified command kinds
  typedef enum logic [2:0] {
    OP_TRANS  = 3'd0,
    OP_INFO   = 3'd1,
    OP_IGNORE = 3'd2,
    OP_CHAR   = 3'd3,
    OP_EOF    = 3'd4,
    OP_NOP    = 3'd5
  } op_e;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    RES_TOKEN   = 2'd0,
    RES_UNKNOWN = 2'd1,
    RES_END     = 2'd2
  } res_kind_e;

  // Source position
  typedef struct packed {
    logic [19:0] line;
    logic [15:0] col;
    logic [31:0] off;
  } pos_t;

  localparam pos_t POS_RESET = '{line: 20'd1, col: 16'd1, off: 32'd0};

  // Classified command as it travels through the command queue
  typedef struct packed {
    op_e        op;
    logic       si_ok;
    logic       ki_ok;
    logic [7:0] state_index;
    logic [7:0] char_code;
    logic [7:0] next_state;
    logic       next_valid;
    logic       accept_flag;
    logic [5:0] kind_index;
    logic       ignore_flag;
  } cmd_t;

  // One result item
  typedef struct packed {
    res_kind_e   kind;
    logic [5:0]  token_kind;
    logic [7:0]  bad_char;
    pos_t        pos;
    logic [15:0] len;
    logic        last;
  } result_t;

  // Number of table slots actually addressable, capped by the field width
  function automatic int slots_of(input int n, input int cap);
    return (n < cap) ? n : cap;
  endfunction

  // Move a position over one consumed character, saturating
  function automatic pos_t pos_advance(input pos_t p, input logic [7:0] c);
    pos_t n;
    n = p;
    if (p.off != '1) n.off = p.off + 32'd1;
    if (c == CHAR_NL) begin
      if (p.line != '1) n.line = p.line + 20'd1;
      n.col = 16'd1;
    end else if (p.col != '1) begin
      n.col = p.col + 16'd1;
    end
    return n;
  endfunction

endpackage

// ===== hdl/dts_fifo.sv =====
// dts_fifo: small register queue used for commands and for results.
// Standalone; no package dependency.

module dts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    if (do_pop)  rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    if (do_push && !do_pop) count_d = count_q + CW'(1);
    if (!do_push && do_pop) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  // Producers and consumers must respect full and empty
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("queue count did not follow a push");

endmodule

// ===== hdl/dts_front.sv =====
// dts_front: input side of the scanner; accepts requests, classifies the
// opcode, checks address ranges and queues commands. Uses dts_pkg, dts_fifo.

module dts_front #(
  parameter int NUM_STATES = 256,
  parameter int NUM_KINDS  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    opcode_i,
  input  logic [7:0]    state_index_i,
  input  logic [7:0]    char_code_i,
  input  logic [7:0]    next_state_i,
  input  logic          next_valid_i,
  input  logic          accept_flag_i,
  input  logic [5:0]    kind_index_i,
  input  logic          ignore_flag_i,
  output logic          cmd_valid_o,
  output dts_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  import dts_pkg::*;

  localparam int ST_SLOTS = slots_of(NUM_STATES, 256);
  localparam int KD_SLOTS = slots_of(NUM_KINDS, 64);

  cmd_t                cmd;
  logic                accept, q_full;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // Classify the opcode; unused codes are dropped here
  always_comb begin
    cmd = '0;
    unique case (opcode_i)
      OPC_TRANS:  cmd.op = OP_TRANS;
      OPC_INFO:   cmd.op = OP_INFO;
      OPC_IGNORE: cmd.op = OP_IGNORE;
      OPC_CHAR:   cmd.op = OP_CHAR;
      OPC_EOF:    cmd.op = OP_EOF;
      default:    cmd.op = OP_NOP;
    endcase
    cmd.si_ok       = ({1'b0, state_index_i} < 9'(ST_SLOTS));
    cmd.ki_ok       = ({1'b0, kind_index_i} < 7'(KD_SLOTS));
    cmd.state_index = state_index_i;
    cmd.char_code   = char_code_i;
    cmd.next_state  = next_state_i;
    cmd.next_valid  = next_valid_i;
    cmd.accept_flag = accept_flag_i;
    cmd.kind_index  = kind_index_i;
    cmd.ignore_flag = ignore_flag_i;
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Command queue toward the engine
  dts_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && (cmd.op != OP_NOP)),
    .wdata_i (cmd),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .valid_o (cmd_valid_o),
    .rdata_o (q_rdata)
  );

  assign cmd_o = cmd_t'(q_rdata);

endmodule

// ===== hdl/dts_engine.sv =====
// dts_engine: back end of the scanner; owns the transition, state-info and
// kind-ignore memories, runs the DFA and builds results. Uses dts_pkg.

module dts_engine #(
  parameter int NUM_STATES = 256,
  parameter int NUM_KINDS  = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             cmd_valid_i,
  input  dts_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output dts_pkg::result_t res_o
);

  import dts_pkg::*;

  localparam int ST_SLOTS = slots_of(NUM_STATES, 256);
  localparam int KD_SLOTS = slots_of(NUM_KINDS, 64);
  localparam int SA_W     = (ST_SLOTS > 1) ? $clog2(ST_SLOTS) : 1;
  localparam int KA_W     = (KD_SLOTS > 1) ? $clog2(KD_SLOTS) : 1;
  localparam int TR_DEPTH = ST_SLOTS * 256;
  localparam int TA_W     = SA_W + 8;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RESOLVE = 6'b000010,
    ST_RESCAN  = 6'b000100,
    ST_UNKNOWN = 6'b001000,
    ST_EOF_TOK = 6'b010000,
    ST_EOF_END = 6'b100000
  } eng_state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] next;
  } trans_t;

  typedef struct packed {
    logic       acc;
    logic [5:0] kind;
  } info_t;

  typedef struct packed {
    logic [5:0]  kind;
    pos_t        pos;
    logic [15:0] len;
  } tok_t;

  // Memories
  trans_t trans_mem [TR_DEPTH];
  info_t  info_mem  [ST_SLOTS];
  logic   ign_mem   [KD_SLOTS];

  trans_t          tr_rd_q;
  info_t           info_rd_q;
  logic            ign_rd_q;
  logic            tr_re, info_re, ign_re, tr_we, info_we, ign_we;
  logic [TA_W-1:0] tr_raddr;
  logic [SA_W-1:0] info_raddr;
  logic [KA_W-1:0] ign_raddr;

  // Control and scan state
  eng_state_e  state_q, state_d;
  logic [7:0]  start_state_q;
  logic [7:0]  cur_state_q, cur_state_d;
  logic        scanning_q, scanning_d;
  logic        acc_q, acc_d;
  logic [5:0]  kind_q, kind_d;
  pos_t        tstart_q, tstart_d;
  logic [15:0] cnt_q, cnt_d;
  pos_t        pos_q, pos_d;
  logic [7:0]  char_q, char_d;
  logic        look_ok_q, look_ok_d;
  logic        info_pend_q, info_pend_d;
  logic        ign_ok_q, ign_ok_d;
  tok_t        tok_q, tok_d;

  // Helpers
  logic [7:0]  scan_state;
  logic        scan_ok, start_ok, ns_ok, eff_kind_ok;
  logic        pend_acc, eff_acc, tr_hit, ignored;
  logic [5:0]  eff_kind;
  logic [15:0] cnt_inc;
  pos_t        pos_next;

  assign scan_state  = scanning_q ? cur_state_q : start_state_q;
  assign scan_ok     = ({1'b0, scan_state} < 9'(ST_SLOTS));
  assign start_ok    = ({1'b0, start_state_q} < 9'(ST_SLOTS));
  assign ns_ok       = ({1'b0, tr_rd_q.next} < 9'(ST_SLOTS));
  assign pend_acc    = info_pend_q && info_rd_q.acc;
  assign eff_acc     = acc_q || pend_acc;
  assign eff_kind    = pend_acc ? info_rd_q.kind : kind_q;
  assign eff_kind_ok = ({1'b0, eff_kind} < 7'(KD_SLOTS));
  assign tr_hit      = look_ok_q && tr_rd_q.valid;
  assign ignored     = ign_ok_q && ign_rd_q;
  assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + 16'd1;
  assign pos_next    = pos_advance(pos_q, char_q);

  function automatic result_t mk_res(input res_kind_e k, input logic [5:0] tk,
                                     input logic [7:0] bad, input pos_t p,
                                     input logic [15:0] len, input logic last);
    result_t r;
    r.kind       = k;
    r.token_kind = tk;
    r.bad_char   = bad;
    r.pos        = p;
    r.len        = len;
    r.last       = last;
    return r;
  endfunction

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cur_state_d = cur_state_q;
    scanning_d  = scanning_q;
    acc_d       = acc_q;
    kind_d      = kind_q;
    tstart_d    = tstart_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    char_d      = char_q;
    look_ok_d   = look_ok_q;
    info_pend_d = 1'b0;
    ign_ok_d    = ign_ok_q;
    tok_d       = tok_q;
    tr_re       = 1'b0;
    tr_we       = 1'b0;
    info_re     = 1'b0;
    info_we     = 1'b0;
    ign_re      = 1'b0;
    ign_we      = 1'b0;
    tr_raddr    = {scan_state[SA_W-1:0], cmd_i.char_code};
    info_raddr  = tr_rd_q.next[SA_W-1:0];
    ign_raddr   = eff_kind[KA_W-1:0];
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = mk_res(RES_TOKEN, tok_q.kind, 8'd0, tok_q.pos, tok_q.len, 1'b0);

    // State info of the state just entered lands in the cycle after its read
    if (pend_acc) begin
      acc_d  = 1'b1;
      kind_d = info_rd_q.kind;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_TRANS: begin
              tr_we     = cmd_i.si_ok;
              cmd_pop_o = 1'b1;
            end
            OP_INFO: begin
              info_we   = cmd_i.si_ok;
              cmd_pop_o = 1'b1;
            end
            OP_IGNORE: begin
              ign_we    = cmd_i.ki_ok;
              cmd_pop_o = 1'b1;
            end
            OP_CHAR: begin
              cmd_pop_o = 1'b1;
              char_d    = cmd_i.char_code;
              if (!scanning_q) begin
                scanning_d  = 1'b1;
                cur_state_d = start_state_q;
                acc_d       = 1'b0;
                kind_d      = '0;
                cnt_d       = '0;
                tstart_d    = pos_q;
              end
              tr_re     = 1'b1;
              look_ok_d = scan_ok;
              state_d   = ST_RESOLVE;
            end
            OP_EOF: begin
              if (scanning_q && eff_acc) begin
                // Pending token goes out first, then the end result
                cmd_pop_o = 1'b1;
                tok_d     = '{kind: eff_kind, pos: tstart_q, len: cnt_q};
                ign_re    = eff_kind_ok;
                ign_ok_d  = eff_kind_ok;
                state_d   = ST_EOF_TOK;
              end else if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o      = mk_res(RES_END, 6'd0, 8'd0,
                                    scanning_q ? tstart_q : pos_q, 16'd0, 1'b1);
                scanning_d  = 1'b0;
                acc_d       = 1'b0;
                kind_d      = '0;
                cnt_d       = '0;
                cur_state_d = start_state_q;
                pos_d       = POS_RESET;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_RESOLVE: begin
        if (tr_hit) begin
          // Consume the character
          cur_state_d = tr_rd_q.next;
          cnt_d       = cnt_inc;
          pos_d       = pos_next;
          info_re     = ns_ok;
          info_pend_d = ns_ok;
          state_d     = ST_IDLE;
        end else if (eff_acc) begin
          // Token ends: hold it, look up its ignore flag, rescan the char
          tok_d       = '{kind: eff_kind, pos: tstart_q, len: cnt_q};
          ign_re      = eff_kind_ok;
          ign_ok_d    = eff_kind_ok;
          scanning_d  = 1'b1;
          cur_state_d = start_state_q;
          acc_d       = 1'b0;
          kind_d      = '0;
          cnt_d       = '0;
          tstart_d    = pos_q;
          tr_re       = 1'b1;
          tr_raddr    = {start_state_q[SA_W-1:0], char_q};
          look_ok_d   = start_ok;
          state_d     = ST_RESCAN;
        end else if (!res_full_i) begin
          // No token: the character is unknown, the prefix is dropped
          res_push_o  = 1'b1;
          res_o       = mk_res(RES_UNKNOWN, 6'd0, char_q, tstart_q, 16'd1, 1'b1);
          pos_d       = pos_next;
          scanning_d  = 1'b0;
          cur_state_d = start_state_q;
          state_d     = ST_IDLE;
        end
      end

      ST_RESCAN: begin
        if (ignored || !res_full_i) begin
          res_push_o = !ignored;
          res_o      = mk_res(RES_TOKEN, tok_q.kind, 8'd0, tok_q.pos, tok_q.len,
                              tr_hit);
          if (tr_hit) begin
            cur_state_d = tr_rd_q.next;
            cnt_d       = cnt_inc;
            pos_d       = pos_next;
            info_re     = ns_ok;
            info_pend_d = ns_ok;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_UNKNOWN;
          end
        end
      end

      ST_UNKNOWN: begin
        if (!res_full_i) begin
          res_push_o  = 1'b1;
          res_o       = mk_res(RES_UNKNOWN, 6'd0, char_q, tstart_q, 16'd1, 1'b1);
          pos_d       = pos_next;
          scanning_d  = 1'b0;
          cur_state_d = start_state_q;
          state_d     = ST_IDLE;
        end
      end

      ST_EOF_TOK: begin
        if (ignored || !res_full_i) begin
          res_push_o = !ignored;
          res_o      = mk_res(RES_TOKEN, tok_q.kind, 8'd0, tok_q.pos, tok_q.len,
                              1'b0);
          state_d    = ST_EOF_END;
        end
      end

      ST_EOF_END: begin
        if (!res_full_i) begin
          res_push_o  = 1'b1;
          res_o       = mk_res(RES_END, 6'd0, 8'd0, pos_q, 16'd0, 1'b1);
          scanning_d  = 1'b0;
          acc_d       = 1'b0;
          kind_d      = '0;
          cnt_d       = '0;
          cur_state_d = start_state_q;
          pos_d       = POS_RESET;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      start_state_q <= 8'd0;
      cur_state_q   <= 8'd0;
      scanning_q    <= 1'b0;
      acc_q         <= 1'b0;
      kind_q        <= '0;
      tstart_q      <= POS_RESET;
      cnt_q         <= '0;
      pos_q         <= POS_RESET;
      look_ok_q     <= 1'b0;
      info_pend_q   <= 1'b0;
      ign_ok_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) start_state_q <= cfg_wdata_i;
      cur_state_q <= cur_state_d;
      scanning_q  <= scanning_d;
      acc_q       <= acc_d;
      kind_q      <= kind_d;
      tstart_q    <= tstart_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      look_ok_q   <= look_ok_d;
      info_pend_q <= info_pend_d;
      ign_ok_q    <= ign_ok_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    tok_q  <= tok_d;
  end

  // Transition memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      trans_mem[{cmd_i.state_index[SA_W-1:0], cmd_i.char_code}] <=
        '{valid: cmd_i.next_valid, next: cmd_i.next_state};
    end
    if (tr_re) tr_rd_q <= trans_mem[tr_raddr];
  end

  // State-info memory
  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[cmd_i.state_index[SA_W-1:0]] <=
        '{acc: cmd_i.accept_flag, kind: cmd_i.kind_index};
    end
    if (info_re) info_rd_q <= info_mem[info_raddr];
  end

  // Kind-ignore memory
  always_ff @(posedge clk_i) begin
    if (ign_we) ign_mem[cmd_i.kind_index[KA_W-1:0]] <= cmd_i.ignore_flag;
    if (ign_re) ign_rd_q <= ign_mem[ign_raddr];
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("engine state not one-hot");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into full queue");

  a_info_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    info_pend_q |-> (state_q == ST_IDLE && scanning_q))
    else $error("state info landed outside idle scan");

  a_tr_read_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_re |=> (state_q == ST_RESOLVE || state_q == ST_RESCAN))
    else $error("transition read not followed by its use");

  a_unknown_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == RES_UNKNOWN) |=> !scanning_q)
    else $error("scan still open after unknown character");

endmodule

// ===== hdl/dfa_token_scanner.sv =====
// Table-driven DFA token scanner, top level.
// Channels: input requests (in_valid_i / in_stall_o) carry one item each:
// table loads (transition, state info, kind ignore), characters, or end of
// input. Results leave on out_valid_o / out_stall_i; an item gives zero to
// two results and the last one carries last_of_run_o. The user must write
// the start state through cfg_we_i / cfg_wdata_i only while the block is
// idle; the block itself does not enforce it.
// Steps: a load is handled in idle; a character takes a registered read of
// the transition memory, then resolve; a character that ends a token needs
// a further step (ignore-flag lookup and rescan read share it), and another
// when the rescan fails and an unknown result follows; end of input with a
// token pending takes a token step before its end result. The transition
// memory has a single registered read port, and the engine takes the next
// command only once it is back in idle. With the engine free and no stall,
// the latest result is an unknown one that follows a failed rescan.
// Reset: scan state and position return to start state 0, line 1, column 1,
// offset 0; table contents are kept undefined until loaded.
// Stall: a stalled result holds; the engine waits once the result queue
// is full, and in_stall_o rises once the command queue is full.
// Uses dts_pkg, dts_front, dts_engine, dts_fifo.

module dfa_token_scanner #(
  parameter int NUM_STATES = dts_pkg::NUM_STATES_DEF,
  parameter int NUM_KINDS  = dts_pkg::NUM_KINDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  state_index_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  next_state_i,
  input  logic        next_valid_i,
  input  logic        accept_flag_i,
  input  logic [5:0]  kind_index_i,
  input  logic        ignore_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  token_kind_o,
  output logic [7:0]  bad_char_o,
  output logic [19:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  import dts_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res_in, res_out;
  logic    res_push, res_full;
  logic [$bits(result_t)-1:0] res_rdata;

  // Front: accept and classify
  dts_front #(
    .NUM_STATES (NUM_STATES),
    .NUM_KINDS  (NUM_KINDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .state_index_i (state_index_i),
    .char_code_i   (char_code_i),
    .next_state_i  (next_state_i),
    .next_valid_i  (next_valid_i),
    .accept_flag_i (accept_flag_i),
    .kind_index_i  (kind_index_i),
    .ignore_flag_i (ignore_flag_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back: DFA engine and tables
  dts_engine #(
    .NUM_STATES (NUM_STATES),
    .NUM_KINDS  (NUM_KINDS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue, decouples the engine from a stalled receiver
  dts_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (out_valid_o && !out_stall_i),
    .valid_o (out_valid_o),
    .rdata_o (res_rdata)
  );

  assign res_out        = result_t'(res_rdata);
  assign result_kind_o  = res_out.kind;
  assign token_kind_o   = res_out.token_kind;
  assign bad_char_o     = res_out.bad_char;
  assign start_line_o   = res_out.pos.line;
  assign start_column_o = res_out.pos.col;
  assign start_offset_o = res_out.pos.off;
  assign token_length_o = res_out.len;
  assign last_of_run_o  = res_out.last;

endmodule

// ===== verif/tb_dfa_token_scanner.sv =====
// Self-checking testbench for dfa_token_scanner: loads small lexers, streams
// characters under random gaps and output stalls, and checks every result.
// Depends on dts_pkg and the dfa_token_scanner RTL; needs no other files.
`timescale 1ns / 100ps

module tb_dfa_token_scanner;
  import dts_pkg::*;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] OPC_SPARE_LO = 3'd5;
  localparam logic [2:0] OPC_SPARE_HI = 3'd7;

  // Directed lexer: characters and token kinds
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_Z    = 8'h7A;
  localparam logic [5:0] KIND_WORD  = 6'd5;
  localparam logic [5:0] KIND_SPACE = 6'd9;
  localparam logic [5:0] KIND_LONG  = 6'd63;

  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_RUN     = 40;
  localparam int PHASE_ITEMS  = 40;

  // One input request
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] si;
    logic [7:0] cc;
    logic [7:0] ns;
    logic       nv;
    logic       af;
    logic [5:0] ki;
    logic       ig;
  } scan_req_t;

  // One result as seen on the output
  typedef struct packed {
    res_kind_e   kind;
    logic [5:0]  tkind;
    logic [7:0]  bad;
    pos_t        at;
    logic [15:0] len;
    logic        last;
  } scan_result_t;

  // DUT signals
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i      = 3'd0;
  logic [7:0]  state_index_i = 8'd0;
  logic [7:0]  char_code_i   = 8'd0;
  logic [7:0]  next_state_i  = 8'd0;
  logic        next_valid_i  = 1'b0;
  logic        accept_flag_i = 1'b0;
  logic [5:0]  kind_index_i  = 6'd0;
  logic        ignore_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  result_kind_o;
  logic [5:0]  token_kind_o;
  logic [7:0]  bad_char_o;
  logic [19:0] start_line_o;
  logic [15:0] start_column_o;
  logic [31:0] start_offset_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  dfa_token_scanner dut (.*);

  // Scanner prediction state
  logic [8:0]  trans_tbl [0:65535];
  logic [6:0]  info_tbl  [0:255];
  logic        ign_tbl   [0:63];
  logic [7:0]  start_st     = 8'd0;
  logic [7:0]  dfa_state    = 8'd0;
  logic        scan_active  = 1'b0;
  logic        accept_hit   = 1'b0;
  logic [5:0]  accept_kind  = 6'd0;
  logic [15:0] tok_len      = 16'd0;
  pos_t        tok_start    = POS_RESET;
  pos_t        stream_pos   = POS_RESET;

  scan_result_t expected_results [$];

  // Current random lexer
  logic [7:0] dfa_states [$];
  logic [7:0] alphabet [$];

  // Bookkeeping
  int  fail_count    = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  token_count   = 0;
  int  unknown_count = 0;
  int  end_count     = 0;
  bit  gaps_allowed  = 1'b1;
  bit  gaps_on       = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic pos_t pos_step(input pos_t p, input logic [7:0] c);
    pos_t q;
    q = p;
    if (q.off != 32'hFFFF_FFFF) q.off = q.off + 32'd1;
    if (c == CHAR_NL) begin
      if (q.line != 20'hF_FFFF) q.line = q.line + 20'd1;
      q.col = 16'd1;
    end else if (q.col != 16'hFFFF) begin
      q.col = q.col + 16'd1;
    end
    return q;
  endfunction

  function automatic scan_result_t make_result(input res_kind_e k, input logic [5:0] tk,
                                               input logic [7:0] bad, input pos_t at,
                                               input logic [15:0] len);
    scan_result_t r;
    r.kind  = k;
    r.tkind = tk;
    r.bad   = bad;
    r.at    = at;
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

  // Open a new token at the current stream position
  function automatic void start_token();
    dfa_state   = start_st;
    accept_hit  = 1'b0;
    accept_kind = 6'd0;
    tok_len     = 16'd0;
    tok_start   = stream_pos;
    scan_active = 1'b1;
  endfunction

  // Take one DFA transition; 0 when the character has none
  function automatic bit dfa_consume(input logic [7:0] c);
    logic [8:0] t;
    t = trans_tbl[{dfa_state, c}];
    if (!t[8]) return 1'b0;
    dfa_state = t[7:0];
    if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
    stream_pos = pos_step(stream_pos, c);
    if (info_tbl[dfa_state][6]) begin
      accept_hit  = 1'b1;
      accept_kind = info_tbl[dfa_state][5:0];
    end
    return 1'b1;
  endfunction

  // Work out the results of one accepted request
  task automatic predict_request(input scan_req_t r);
    scan_result_t outs [2];
    int n;
    bit taken;
    n = 0;
    unique case (r.op)
      OPC_TRANS:  trans_tbl[{r.si, r.cc}] = {r.nv, r.ns};
      OPC_INFO:   info_tbl[r.si] = {r.af, r.ki};
      OPC_IGNORE: ign_tbl[r.ki] = r.ig;
      OPC_CHAR: begin
        if (!scan_active) start_token();
        taken = dfa_consume(r.cc);
        if (!taken && accept_hit) begin
          if (!ign_tbl[accept_kind]) begin
            outs[n] = make_result(RES_TOKEN, accept_kind, 8'd0, tok_start, tok_len);
            n++;
          end
          // rescan the breaking character from the start state
          start_token();
          taken = dfa_consume(r.cc);
        end
        if (!taken) begin
          outs[n] = make_result(RES_UNKNOWN, 6'd0, r.cc, tok_start, 16'd1);
          n++;
          stream_pos  = pos_step(stream_pos, r.cc);
          scan_active = 1'b0;
          dfa_state   = start_st;
        end
      end
      OPC_EOF: begin
        if (scan_active && accept_hit) begin
          if (!ign_tbl[accept_kind]) begin
            outs[n] = make_result(RES_TOKEN, accept_kind, 8'd0, tok_start, tok_len);
            n++;
          end
          outs[n] = make_result(RES_END, 6'd0, 8'd0, stream_pos, 16'd0);
        end else if (scan_active) begin
          // prefix with no accepting state is dropped
          outs[n] = make_result(RES_END, 6'd0, 8'd0, tok_start, 16'd0);
        end else begin
          outs[n] = make_result(RES_END, 6'd0, 8'd0, stream_pos, 16'd0);
        end
        n++;
        scan_active = 1'b0;
        accept_hit  = 1'b0;
        accept_kind = 6'd0;
        tok_len     = 16'd0;
        dfa_state   = start_st;
        stream_pos  = POS_RESET;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) outs[i].last = 1'b1;
      expected_results = {expected_results, outs[i]};
    end
  endtask

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Random idle before a request: mostly none or short, a few long
  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 55) len = 0;
    else if (pick < 88) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 60);
    if (len != 0) begin
      in_valid_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Drive one request and wait until it is taken
  task automatic send_request(input scan_req_t r);
    if (gaps_allowed && $urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    sender_gap();
    opcode_i      <= r.op;
    state_index_i <= r.si;
    char_code_i   <= r.cc;
    next_state_i  <= r.ns;
    next_valid_i  <= r.nv;
    accept_flag_i <= r.af;
    kind_index_i  <= r.ki;
    ignore_flag_i <= r.ig;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    predict_request(r);
  endtask

  // Random filler for fields a request does not use
  function automatic scan_req_t noise_req(input logic [2:0] op);
    scan_req_t r;
    r.op = op;
    r.si = 8'($urandom_range(0, 255));
    r.cc = 8'($urandom_range(0, 255));
    r.ns = 8'($urandom_range(0, 255));
    r.nv = 1'($urandom_range(0, 1));
    r.af = 1'($urandom_range(0, 1));
    r.ki = 6'($urandom_range(0, 63));
    r.ig = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_trans(input logic [7:0] si, input logic [7:0] c,
                            input logic [7:0] ns, input logic nv);
    scan_req_t r;
    r = noise_req(OPC_TRANS);
    r.si = si;
    r.cc = c;
    r.ns = ns;
    r.nv = nv;
    send_request(r);
  endtask

  task automatic send_info(input logic [7:0] si, input logic af, input logic [5:0] ki);
    scan_req_t r;
    r = noise_req(OPC_INFO);
    r.si = si;
    r.af = af;
    r.ki = ki;
    send_request(r);
  endtask

  task automatic send_ignore(input logic [5:0] ki, input logic ig);
    scan_req_t r;
    r = noise_req(OPC_IGNORE);
    r.ki = ki;
    r.ig = ig;
    send_request(r);
  endtask

  task automatic send_char(input logic [7:0] c);
    scan_req_t r;
    r = noise_req(OPC_CHAR);
    r.cc = c;
    send_request(r);
  endtask

  task automatic send_eof();
    send_request(noise_req(OPC_EOF));
  endtask

  // Hold off until every expected result is out, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_state(input logic [7:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    start_st = v;
  endtask

  // Random lexer over a few states and characters; every (state, char)
  // pair it can reach is written, and every valid target stays inside it
  task automatic build_lexer(input int n_st, input int n_ch);
    logic [7:0] s;
    dfa_states.delete();
    alphabet.delete();
    dfa_states = {dfa_states, start_st};
    for (int i = 1; i < n_st; i++) dfa_states = {dfa_states, 8'($urandom_range(0, 255))};
    for (int i = 0; i < n_ch; i++) alphabet = {alphabet, 8'($urandom_range(0, 255))};
    if ($urandom_range(0, 1)) alphabet = {alphabet, CHAR_NL};
    for (int i = 0; i < dfa_states.size(); i++) begin
      for (int j = 0; j < alphabet.size(); j++) begin
        if ($urandom_range(0, 99) < 60)
          send_trans(dfa_states[i], alphabet[j],
                     dfa_states[$urandom_range(0, dfa_states.size() - 1)], 1'b1);
        else
          send_trans(dfa_states[i], alphabet[j], 8'($urandom_range(0, 255)), 1'b0);
      end
    end
    for (int i = 0; i < dfa_states.size(); i++) begin
      s = dfa_states[i];
      send_info(s, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      send_ignore(info_tbl[s][5:0], $urandom_range(0, 3) == 0);
    end
  endtask

  // Mostly characters of the current lexer, with table rewrites, end of
  // input and dead opcodes mixed in
  task automatic run_stream(input int count, input bit hold_off);
    scan_req_t r;
    int pick;
    bit hit_s;
    bit hit_c;
    for (int k = 0; k < count; k++) begin
      if (hold_off && k == count / 2) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        send_char(alphabet[$urandom_range(0, alphabet.size() - 1)]);
      end else if (pick < 88) begin
        send_eof();
      end else if (pick < 92) begin
        r = noise_req(OPC_TRANS);
        if ($urandom_range(0, 1)) begin
          r.si = dfa_states[$urandom_range(0, dfa_states.size() - 1)];
          r.cc = alphabet[$urandom_range(0, alphabet.size() - 1)];
        end
        hit_s = 1'b0;
        hit_c = 1'b0;
        for (int i = 0; i < dfa_states.size(); i++) if (dfa_states[i] == r.si) hit_s = 1'b1;
        for (int i = 0; i < alphabet.size(); i++) if (alphabet[i] == r.cc) hit_c = 1'b1;
        // keep reachable entries pointing inside the lexer
        if (hit_s && hit_c) r.ns = dfa_states[$urandom_range(0, dfa_states.size() - 1)];
        send_request(r);
      end else if (pick < 95) begin
        send_request(noise_req(OPC_INFO));
      end else if (pick < 98) begin
        send_request(noise_req(OPC_IGNORE));
      end else begin
        send_request(noise_req(3'($urandom_range(OPC_SPARE_HI, OPC_SPARE_LO))));
      end
    end
    send_eof();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every kind-ignore entry gets a defined value
  task automatic test_table_init();
    for (int k = 0; k < 64; k++) send_ignore(6'(k), 1'b0);
  endtask

  // Hand-built lexer: words, ignored blanks, a dash prefix that needs a
  // following letter, and characters with no transition at all
  task automatic test_directed_tokens();
    logic [7:0] chars [7];
    chars = '{CH_A, CH_SP, CHAR_NL, CH_DASH, CH_HASH, 8'hFF, 8'h00};
    for (int s = 0; s < 4; s++)
      for (int j = 0; j < 7; j++) send_trans(8'(s), chars[j], 8'hFF, 1'b0);
    send_trans(8'd0, CH_A, 8'd1, 1'b1);
    send_trans(8'd1, CH_A, 8'd1, 1'b1);
    send_trans(8'd1, 8'hFF, 8'd1, 1'b1);
    send_trans(8'd0, CH_SP, 8'd2, 1'b1);
    send_trans(8'd2, CH_SP, 8'd2, 1'b1);
    send_trans(8'd0, CHAR_NL, 8'd2, 1'b1);
    send_trans(8'd2, CHAR_NL, 8'd2, 1'b1);
    send_trans(8'd0, CH_DASH, 8'd3, 1'b1);
    send_trans(8'd3, CH_A, 8'd1, 1'b1);
    send_info(8'd0, 1'b0, 6'd0);
    send_info(8'd1, 1'b1, KIND_WORD);
    send_info(8'd2, 1'b1, KIND_SPACE);
    send_info(8'd3, 1'b0, KIND_LONG);
    send_ignore(KIND_WORD, 1'b0);
    send_ignore(KIND_SPACE, 1'b1);
    // word, blank, word ended by a character nothing accepts
    send_char(CH_A);
    send_char(CH_A);
    send_char(CH_SP);
    send_char(CH_A);
    send_char(CH_HASH);
    // prefix without an accepting state, then one left open at end of input
    send_char(CH_DASH);
    send_char(CH_HASH);
    send_char(CH_DASH);
    send_eof();
    send_eof();
    // newline as an ignored token, word pending at end of input
    send_char(CH_A);
    send_char(CHAR_NL);
    send_char(CH_A);
    send_char(8'hFF);
    send_eof();
    // ignored token flushed by end of input, then by an unknown character
    send_char(CH_SP);
    send_eof();
    send_char(CH_SP);
    send_char(CH_HASH);
    send_char(8'h00);
    for (int op = OPC_SPARE_LO; op <= OPC_SPARE_HI; op++) send_request(noise_req(3'(op)));
    send_eof();
  endtask

  // One long token sent back to back from the highest start state
  task automatic test_long_token();
    gaps_allowed = 1'b0;
    gaps_on      = 1'b0;
    write_start_state(8'hFF);
    send_trans(8'hFF, CH_Z, 8'hFE, 1'b1);
    send_trans(8'hFE, CH_Z, 8'hFE, 1'b1);
    send_info(8'hFF, 1'b0, 6'd0);
    send_info(8'hFE, 1'b1, KIND_LONG);
    send_ignore(KIND_LONG, 1'b0);
    for (int i = 0; i < LONG_RUN; i++) send_char(CH_Z);
    send_eof();
    gaps_allowed = 1'b1;
    gaps_on      = 1'b1;
  endtask

  // Random lexers under several start states, extremes included
  task automatic test_random_streams();
    logic [7:0] v;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) v = 8'h00;
      else if (p == 2) v = 8'hFF;
      else v = 8'($urandom_range(0, 255));
      write_start_state(v);
      build_lexer($urandom_range(2, 6), $urandom_range(3, 8));
      run_stream(PHASE_ITEMS, p == 1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Output stall: free stretches, choppy stretches, and a few long holds
  initial begin
    int pick;
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
        repeat ($urandom_range(0, 40)) @(posedge clk_i);
      end else if (pick < 9) begin
        repeat ($urandom_range(5, 30)) begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    scan_result_t got;
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind  = res_kind_e'(result_kind_o);
      got.tkind = token_kind_o;
      got.bad   = bad_char_o;
      got.at    = '{line: start_line_o, col: start_column_o, off: start_offset_o};
      got.len   = token_length_o;
      got.last  = last_of_run_o;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with none expected: kind %0d tok %0d len %0d",
                   $realtime, got.kind, got.tkind, got.len);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        unique case (want.kind)
          RES_TOKEN:   token_count++;
          RES_UNKNOWN: unknown_count++;
          default:     end_count++;
        endcase
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch on result %0d", $realtime, checked_count);
            $display("  expected kind %0d tok %0d bad %h line %0d col %0d off %0d",
                     want.kind, want.tkind, want.bad, want.at.line, want.at.col,
                     want.at.off, " len %0d last %b", want.len, want.last);
            $display("  actual   kind %0d tok %0d bad %h line %0d col %0d off %0d",
                     got.kind, got.tkind, got.bad, got.at.line, got.at.col,
                     got.at.off, " len %0d last %b", got.len, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    int waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_init();
    test_directed_tokens();
    test_long_token();
    test_random_streams();

    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    fail_count += expected_results.size();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (directed lexer, one long token, 6 random lexers).",
             sent_count);
    $display("Checked %0d results: %0d tokens, %0d unknown characters, %0d end of input.",
             checked_count, token_count, unknown_count, end_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
